/* design/led_wp_pkg.sv */
// Shared types, constants and the sine table entry function for the wave pattern pixel core.
package led_wp_pkg;

    localparam int INDEX_W = 12;
    localparam int PHASE_W = 16;
    localparam int COLOR_W = 24;
    localparam int RECIP_W = 24;
    localparam int DEPTH_W = 8;
    localparam int WAVE_W  = 17;    // Q1.15 plus room for +1.0
    localparam int SCALE_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RECIP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_DEPTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COLOR  = 3'd5;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } wave_sel_t;

    typedef logic signed [WAVE_W-1:0] wave_t;

    localparam logic [PHASE_W-1:0] RST_PIXEL_STEP = 16'd4096;
    localparam logic [RECIP_W-1:0] RST_STEP_RECIP = 24'd4096;
    localparam logic [DEPTH_W-1:0] RST_WAVE_DEPTH = 8'd255;
    localparam logic [COLOR_W-1:0] RST_BASE_COLOR = 24'hFFFFFF;

    localparam logic [WAVE_W-1:0] Q15_ONE    = 17'd32768;
    localparam logic [SCALE_W-1:0] SCALE_MAX = 24'd16711680;   // 510 * 32768
    localparam logic [SCALE_W-1:0] SCALE_MID = 24'd8355840;    // 255 * 32768

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Sine entry in Q1.15 from a UQ0.32 fraction of a cycle; elaboration-time only.
    function automatic wave_t sine_value(input logic [63:0] frac);
        logic [1:0]  quad;
        logic [63:0] r;
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] mag;
        wave_t       m17;
        quad = frac[31:30];
        r = {34'd0, frac[29:0]};
        if (quad[0])
            r = Q30_ONE - r;
        theta = (r * HALF_PI_Q30) >> 30;
        t2 = (theta * theta) >> 30;
        acc = Q30_ONE;
        acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd110;
        acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd72;
        acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd42;
        acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd20;
        acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd6;
        s = (theta * acc) >> 30;
        mag = (s + 64'd16384) >> 15;
        if (mag > 64'd32768)
            mag = 64'd32768;
        m17 = wave_t'(mag[WAVE_W-1:0]);
        return quad[1] ? -m17 : m17;
    endfunction

endpackage

/* design/led_wave_pattern_pixel_core.sv */
// Wave pattern pixel core: pixel index in, scaled base color out, five-stage pipeline.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+---------------------------
//  pixel in | start, busy, pixel_index                  | taken when start && !busy
//  color out| done, pixel_index_out, pixel_color        | one-cycle strobe on done
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | write when valid && ready
//
// One pixel per cycle; a word's color and done leave the fifth register stage.
// Stages: phase multiply, square region and sine ROM read, ramp multiply and
// wave select, depth multiply and clamp, per-channel color multiply into the output register.
// busy stays low and cfg_ready stays high: the result side never stalls.
// Reset clears the valid bits and the config registers to their defaults.
module led_wave_pattern_pixel_core #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [led_wp_pkg::INDEX_W-1:0]         pixel_index,
    output logic                                   done,
    output logic [led_wp_pkg::INDEX_W-1:0]         pixel_index_out,
    output logic [led_wp_pkg::COLOR_W-1:0]         pixel_color,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [led_wp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [led_wp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int KW = (SINE_TABLE_ENTRIES > 1) ? $clog2(SINE_TABLE_ENTRIES) : 1;
    localparam int KPW = led_wp_pkg::PHASE_W + KW + 1;
    localparam int PH_MUL_W = led_wp_pkg::PHASE_W + led_wp_pkg::INDEX_W;
    localparam int RAMP_W = led_wp_pkg::WAVE_W + led_wp_pkg::RECIP_W;
    localparam int DPROD_W = led_wp_pkg::DEPTH_W + 1 + led_wp_pkg::WAVE_W;
    localparam int CPROD_W = 8 + led_wp_pkg::SCALE_W;

    typedef enum logic [1:0] {
        SQ_RAMP,
        SQ_HIGH,
        SQ_LOW
    } sq_sel_t;

    // config registers
    led_wp_pkg::wave_sel_t               waveform_reg;
    logic [led_wp_pkg::PHASE_W-1:0]      pixel_step_reg;
    logic [led_wp_pkg::RECIP_W-1:0]      step_recip_reg;
    logic [led_wp_pkg::PHASE_W-1:0]      phase_ofs_reg;
    logic [led_wp_pkg::DEPTH_W-1:0]      wave_depth_reg;
    logic [led_wp_pkg::COLOR_W-1:0]      base_color_reg;

    // sine ROM
    led_wp_pkg::wave_t                   sine_rom [SINE_TABLE_ENTRIES];

    // stage 1
    logic                                s1_valid_reg;
    logic [led_wp_pkg::INDEX_W-1:0]      s1_index_reg;
    logic [led_wp_pkg::PHASE_W-1:0]      s1_phase_reg;
    logic [PH_MUL_W-1:0]                 phase_prod;

    // stage 2
    logic                                s2_valid_reg;
    logic [led_wp_pkg::INDEX_W-1:0]      s2_index_reg;
    led_wp_pkg::wave_t                   s2_sine_reg;
    sq_sel_t                             s2_sq_sel_reg;
    sq_sel_t                             sq_sel_next;
    logic [led_wp_pkg::WAVE_W-1:0]       s2_ramp_mag_reg;
    logic [led_wp_pkg::WAVE_W-1:0]       ramp_mag_next;
    logic                                s2_ramp_neg_reg;
    logic                                ramp_neg_next;
    led_wp_pkg::wave_t                   s2_lin_reg;
    led_wp_pkg::wave_t                   lin_next;
    logic [KPW-1:0]                      sine_addr_full;
    logic [KW-1:0]                       sine_addr;
    logic signed [17:0]                  xs;
    logic signed [17:0]                  fs;
    logic signed [17:0]                  ramp_d;
    logic signed [17:0]                  ramp_abs;
    logic signed [17:0]                  tri_val;

    // stage 3
    logic                                s3_valid_reg;
    logic [led_wp_pkg::INDEX_W-1:0]      s3_index_reg;
    led_wp_pkg::wave_t                   s3_wave_reg;
    led_wp_pkg::wave_t                   wave_next;
    logic [RAMP_W-1:0]                   ramp_prod;
    logic [RAMP_W-10:0]                  ramp_shift;
    logic [led_wp_pkg::WAVE_W-1:0]       ramp_clamp;
    led_wp_pkg::wave_t                   sq_val;

    // stage 4
    logic                                s4_valid_reg;
    logic [led_wp_pkg::INDEX_W-1:0]      s4_index_reg;
    logic [led_wp_pkg::SCALE_W-1:0]      s4_scale_reg;
    logic [led_wp_pkg::SCALE_W-1:0]      scale_next;
    logic signed [DPROD_W-1:0]           depth_prod;
    logic signed [DPROD_W-1:0]           scale_sum;

    // output stage
    logic                                done_reg;
    logic [led_wp_pkg::INDEX_W-1:0]      index_out_reg;
    logic [led_wp_pkg::COLOR_W-1:0]      color_reg;
    logic [led_wp_pkg::COLOR_W-1:0]      color_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    for (genvar g = 0; g < SINE_TABLE_ENTRIES; g++) begin : g_sine
        localparam logic [63:0] FRAC = (64'(g) << 32) / SINE_TABLE_ENTRIES;
        assign sine_rom[g] = led_wp_pkg::sine_value(FRAC);
    end

    // config writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg   <= led_wp_pkg::WAVE_SINE;
            pixel_step_reg <= led_wp_pkg::RST_PIXEL_STEP;
            step_recip_reg <= led_wp_pkg::RST_STEP_RECIP;
            phase_ofs_reg  <= '0;
            wave_depth_reg <= led_wp_pkg::RST_WAVE_DEPTH;
            base_color_reg <= led_wp_pkg::RST_BASE_COLOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                led_wp_pkg::REG_WAVEFORM:
                    waveform_reg <= led_wp_pkg::wave_sel_t'(cfg_data[1:0]);
                led_wp_pkg::REG_PIXEL_STEP:
                    pixel_step_reg <= cfg_data[led_wp_pkg::PHASE_W-1:0];
                led_wp_pkg::REG_STEP_RECIP:
                    step_recip_reg <= cfg_data[led_wp_pkg::RECIP_W-1:0];
                led_wp_pkg::REG_PHASE_OFS:
                    phase_ofs_reg <= cfg_data[led_wp_pkg::PHASE_W-1:0];
                led_wp_pkg::REG_WAVE_DEPTH:
                    wave_depth_reg <= cfg_data[led_wp_pkg::DEPTH_W-1:0];
                led_wp_pkg::REG_BASE_COLOR:
                    base_color_reg <= cfg_data[led_wp_pkg::COLOR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // stage 1: phase = step * index + offset, modulo one cycle
    assign phase_prod = PH_MUL_W'(pixel_step_reg) * PH_MUL_W'(pixel_index);

    // stage 2: sine address, square region and ramp input, linear waves
    always_comb
    begin
        sine_addr_full = KPW'(s1_phase_reg) * KPW'(SINE_TABLE_ENTRIES);
        sine_addr = sine_addr_full[led_wp_pkg::PHASE_W +: KW];

        xs = signed'({2'b00, s1_phase_reg});
        fs = signed'({2'b00, pixel_step_reg});
        ramp_d = xs;
        sq_sel_next = SQ_RAMP;
        if (xs < fs)
        begin
            sq_sel_next = SQ_RAMP;
            ramp_d = xs;
        end
        else if (xs <= 18'sd32768 - fs)
            sq_sel_next = SQ_HIGH;
        else if (xs < 18'sd32768 + fs)
        begin
            sq_sel_next = SQ_RAMP;
            ramp_d = 18'sd32768 - xs;
        end
        else if (xs <= 18'sd65536 - fs)
            sq_sel_next = SQ_LOW;
        else
        begin
            sq_sel_next = SQ_RAMP;
            ramp_d = xs - 18'sd65536;
        end
        ramp_neg_next = ramp_d[17];
        ramp_abs = ramp_d[17] ? -ramp_d : ramp_d;
        ramp_mag_next = ramp_abs[led_wp_pkg::WAVE_W-1:0];

        if (s1_phase_reg[15] == 1'b0)
            tri_val = (xs <<< 1) - 18'sd32768;
        else
            tri_val = 18'sd98304 - (xs <<< 1);
        if (waveform_reg == led_wp_pkg::WAVE_TRIANGLE)
            lin_next = tri_val[led_wp_pkg::WAVE_W-1:0];
        else
            lin_next = led_wp_pkg::wave_t'(xs - 18'sd32768);
    end

    // stage 3: ramp multiply, clamp, waveform select
    always_comb
    begin
        ramp_prod = RAMP_W'(s2_ramp_mag_reg) * RAMP_W'(step_recip_reg);
        ramp_shift = ramp_prod[RAMP_W-1:9];
        if (ramp_shift > (RAMP_W-9)'(led_wp_pkg::Q15_ONE))
            ramp_clamp = led_wp_pkg::Q15_ONE;
        else
            ramp_clamp = ramp_shift[led_wp_pkg::WAVE_W-1:0];

        case (s2_sq_sel_reg)
            SQ_HIGH:  sq_val = led_wp_pkg::wave_t'(led_wp_pkg::Q15_ONE);
            SQ_LOW:   sq_val = -led_wp_pkg::wave_t'(led_wp_pkg::Q15_ONE);
            default:  sq_val = s2_ramp_neg_reg ? -led_wp_pkg::wave_t'(ramp_clamp)
                                               : led_wp_pkg::wave_t'(ramp_clamp);
        endcase

        unique case (waveform_reg)
            led_wp_pkg::WAVE_SINE:   wave_next = s2_sine_reg;
            led_wp_pkg::WAVE_SQUARE: wave_next = sq_val;
            default:                 wave_next = s2_lin_reg;
        endcase
    end

    // stage 4: scale = 255*32768 + depth * wave, clamped
    always_comb
    begin
        depth_prod = signed'({1'b0, wave_depth_reg}) * DPROD_W'(s3_wave_reg);
        scale_sum = signed'(DPROD_W'(led_wp_pkg::SCALE_MID)) + depth_prod;
        if (scale_sum < 0)
            scale_next = '0;
        else if (scale_sum > signed'(DPROD_W'(led_wp_pkg::SCALE_MAX)))
            scale_next = led_wp_pkg::SCALE_MAX;
        else
            scale_next = scale_sum[led_wp_pkg::SCALE_W-1:0];
    end

    // stage 5: channel * scale / (255 * 65536); the /255 is done by shift-add
    always_comb
    begin
        logic [CPROD_W-1:0] cprod;
        logic [16:0]        q;
        logic [16:0]        qd;
        color_next = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            cprod = CPROD_W'(base_color_reg[ch*8 +: 8]) * CPROD_W'(s4_scale_reg);
            q = {1'b0, cprod[CPROD_W-1 -: 16]};
            qd = (q + (q >> 8) + 17'd1) >> 8;
            color_next[ch*8 +: 8] = qd[7:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_index_reg <= pixel_index;
        s1_phase_reg <= phase_prod[led_wp_pkg::PHASE_W-1:0] + phase_ofs_reg;

        s2_index_reg    <= s1_index_reg;
        s2_sine_reg     <= sine_rom[sine_addr];
        s2_sq_sel_reg   <= sq_sel_next;
        s2_ramp_mag_reg <= ramp_mag_next;
        s2_ramp_neg_reg <= ramp_neg_next;
        s2_lin_reg      <= lin_next;

        s3_index_reg <= s2_index_reg;
        s3_wave_reg  <= wave_next;

        s4_index_reg <= s3_index_reg;
        s4_scale_reg <= scale_next;

        index_out_reg <= s4_index_reg;
        color_reg     <= color_next;
    end

    assign done            = done_reg;
    assign pixel_index_out = index_out_reg;
    assign pixel_color     = color_reg;

endmodule
